// File: src/pvfr_pkg.sv
// Package with the shared types and codes of the pulsed valve flow regulator.
package pvfr_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_FLOW_SETPOINT = 2'd0;
    localparam logic [1:0] CFG_PULSE_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_CLOSED_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_FULL_LIMIT    = 2'd3;

    // Register values after reset.
    localparam logic [15:0] RST_FLOW_SETPOINT = 16'd0;
    localparam logic [7:0]  RST_PULSE_LENGTH  = 8'd6;
    localparam logic [7:0]  RST_CLOSED_LIMIT  = 8'd12;
    localparam logic [7:0]  RST_FULL_LIMIT    = 8'd243;

    // Operation codes of an input item.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // External state codes, as seen on new_state and state_code.
    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_OPENING = 3'd1;
    localparam logic [2:0] CODE_CLOSING = 3'd2;
    localparam logic [2:0] CODE_PULSE_O = 3'd3;
    localparam logic [2:0] CODE_PULSE_C = 3'd4;
    localparam logic [2:0] CODE_SET     = 3'd5;
    localparam logic [2:0] CODE_ERROR   = 3'd6;
    localparam logic [2:0] CODE_INVALID = 3'd7;

    // Controller state, one-hot inside the block.
    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_OPENING = 8'b0000_0010,
        ST_CLOSING = 8'b0000_0100,
        ST_PULSE_O = 8'b0000_1000,
        ST_PULSE_C = 8'b0001_0000,
        ST_SET     = 8'b0010_0000,
        ST_ERROR   = 8'b0100_0000,
        ST_INVALID = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  valve_position;
        logic [15:0] flow;
        logic [2:0]  new_state;
        logic        new_open_drive;
        logic        new_close_drive;
    } in_item_t;

    typedef struct packed {
        logic       open_drive;
        logic       close_drive;
        logic [2:0] state_code;
    } out_item_t;

    typedef struct packed {
        logic [15:0] flow_setpoint;
        logic [7:0]  pulse_length;
        logic [7:0]  closed_limit;
        logic [7:0]  full_limit;
    } cfg_t;

    typedef struct packed {
        state_t     state;
        logic [7:0] timer;
        logic       open_bit;
        logic       close_bit;
    } ctrl_t;

    function automatic state_t code_to_state(input logic [2:0] code);
        state_t s;
        case (code)
            CODE_IDLE:    s = ST_IDLE;
            CODE_OPENING: s = ST_OPENING;
            CODE_CLOSING: s = ST_CLOSING;
            CODE_PULSE_O: s = ST_PULSE_O;
            CODE_PULSE_C: s = ST_PULSE_C;
            CODE_SET:     s = ST_SET;
            CODE_ERROR:   s = ST_ERROR;
            default:      s = ST_INVALID;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] state_to_code(input state_t s);
        logic [2:0] code;
        case (s)
            ST_IDLE:    code = CODE_IDLE;
            ST_OPENING: code = CODE_OPENING;
            ST_CLOSING: code = CODE_CLOSING;
            ST_PULSE_O: code = CODE_PULSE_O;
            ST_PULSE_C: code = CODE_PULSE_C;
            ST_SET:     code = CODE_SET;
            ST_ERROR:   code = CODE_ERROR;
            default:    code = CODE_INVALID;
        endcase
        return code;
    endfunction

endpackage

// File: src/pvfr_step.sv
// Next-state logic of the regulator for one tick or command transaction.
module pvfr_step
    import pvfr_pkg::*;
(
    input  ctrl_t    cur,
    input  cfg_t     cfg,
    input  in_item_t item,
    output ctrl_t    nxt
);

    logic [16:0] flow_ext;
    logic [16:0] sp_ext;
    logic        flow_ge_sp;
    logic        flow_gt_sp;
    logic        flow_lt_sp;
    logic        flow_lt_sp_m1;
    logic        flow_gt_sp_p1;
    logic        pos_above_full;
    logic        pos_below_closed;
    logic        timer_zero;

    assign flow_ext         = {1'b0, item.flow};
    assign sp_ext           = {1'b0, cfg.flow_setpoint};
    assign flow_ge_sp       = item.flow >= cfg.flow_setpoint;
    assign flow_gt_sp       = item.flow > cfg.flow_setpoint;
    assign flow_lt_sp       = item.flow < cfg.flow_setpoint;
    // Widened by one bit so that flow plus one and setpoint plus one cannot wrap.
    assign flow_lt_sp_m1    = (flow_ext + 17'd1) < sp_ext;
    assign flow_gt_sp_p1    = flow_ext > (sp_ext + 17'd1);
    assign pos_above_full   = item.valve_position > cfg.full_limit;
    assign pos_below_closed = item.valve_position < cfg.closed_limit;
    assign timer_zero       = cur.timer == 8'd0;

    always_comb
    begin
        nxt = cur;
        if (item.op == OP_COMMAND)
        begin
            nxt.state     = code_to_state(item.new_state);
            nxt.open_bit  = item.new_open_drive;
            nxt.close_bit = item.new_close_drive;
        end
        else
        begin
            case (cur.state)
                ST_IDLE:
                begin
                end
                ST_OPENING:
                begin
                    if (flow_ge_sp || pos_above_full)
                    begin
                        nxt.open_bit  = 1'b0;
                        nxt.close_bit = 1'b0;
                        nxt.state     = ST_SET;
                    end
                end
                ST_CLOSING:
                begin
                    if (pos_below_closed)
                    begin
                        nxt.open_bit  = 1'b0;
                        nxt.close_bit = 1'b0;
                        nxt.state     = ST_IDLE;
                    end
                end
                ST_PULSE_O, ST_PULSE_C:
                begin
                    nxt.timer = cur.timer - 8'd1;
                    if (timer_zero
                        || ((cur.state == ST_PULSE_O) && flow_gt_sp)
                        || ((cur.state == ST_PULSE_C) && flow_lt_sp))
                    begin
                        nxt.open_bit  = 1'b0;
                        nxt.close_bit = 1'b0;
                        nxt.state     = ST_SET;
                    end
                end
                ST_SET:
                begin
                    if (flow_lt_sp_m1 && !pos_above_full)
                    begin
                        nxt.open_bit  = 1'b1;
                        nxt.close_bit = 1'b0;
                        nxt.state     = ST_PULSE_O;
                        nxt.timer     = cfg.pulse_length;
                    end
                    else if (flow_gt_sp_p1 && !pos_below_closed)
                    begin
                        nxt.open_bit  = 1'b0;
                        nxt.close_bit = 1'b1;
                        nxt.state     = ST_PULSE_C;
                        nxt.timer     = cfg.pulse_length;
                    end
                end
                ST_ERROR:
                begin
                    nxt.open_bit  = 1'b0;
                    nxt.close_bit = 1'b0;
                end
                default:
                begin
                    nxt.open_bit  = 1'b0;
                    nxt.close_bit = 1'b0;
                    nxt.state     = ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/pulsed_valve_flow_regulator.sv
// Top level of the pulsed valve flow regulator: handshakes, registers and state.
// The result of a transaction is in the output register from the edge that accepts it.
// Throughput: one transaction per cycle unless out_stall holds a result, set by the
// single next-state step that reads the state registers and writes them back on the
// accepting edge.
// Reset: rst_n clears the state to idle, the timer and both drives to zero, the
// output register to empty and the configuration registers to their defaults.
module pulsed_valve_flow_regulator
    import pvfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers. The port always takes a write; software only writes while
    // the regulator is idle, and the block itself does not enforce this.
    cfg_t      cfg_reg;
    cfg_t      cfg_next;

    // Controller state: state, pulse timer and the two drive bits.
    ctrl_t     ctrl_reg;
    ctrl_t     ctrl_next;

    // Output register holding the result of the most recent transaction.
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    logic      in_accept;
    logic      out_accept;

    assign cfg_ready = 1'b1;

    // The input side stalls only while a result is held and the output side
    // refuses it. When the result drains in this cycle, a new transaction is
    // taken at the same edge, so items flow back to back.
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FLOW_SETPOINT: cfg_next.flow_setpoint = cfg_data;
                CFG_PULSE_LENGTH:  cfg_next.pulse_length  = cfg_data[7:0];
                CFG_CLOSED_LIMIT:  cfg_next.closed_limit  = cfg_data[7:0];
                CFG_FULL_LIMIT:    cfg_next.full_limit    = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // One full controller step per transaction, straight from the accepted
    // payload and the current state.
    ctrl_t step_result;

    pvfr_step u_step (
        .cur  (ctrl_reg),
        .cfg  (cfg_reg),
        .item (in_data),
        .nxt  (step_result)
    );

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            ctrl_next                = step_result;
            out_valid_next           = 1'b1;
            out_data_next.open_drive  = step_result.open_bit;
            out_data_next.close_drive = step_result.close_bit;
            out_data_next.state_code  = state_to_code(step_result.state);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_setpoint <= RST_FLOW_SETPOINT;
            cfg_reg.pulse_length  <= RST_PULSE_LENGTH;
            cfg_reg.closed_limit  <= RST_CLOSED_LIMIT;
            cfg_reg.full_limit    <= RST_FULL_LIMIT;
            ctrl_reg.state        <= ST_IDLE;
            ctrl_reg.timer        <= 8'd0;
            ctrl_reg.open_bit     <= 1'b0;
            ctrl_reg.close_bit    <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            ctrl_reg      <= ctrl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
